// ----- design/pidl_pkg.sv -----
package pidl_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int POS_W        = 8;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int CNT_OUT_W    = 8;

    typedef enum logic [OP_W-1:0] {
        OP_READ    = 3'd0,
        OP_INSERT  = 3'd1,
        OP_REPLACE = 3'd2,
        OP_DELETE  = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Command broadcast to every cell for one accepted request.
    typedef struct packed {
        logic                     shift_up;
        logic                     shift_down;
        logic                     write;
        logic                     read;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

// ----- design/pidl_cell.sv -----
module pidl_cell #(
    parameter int CAPACITY = pidl_pkg::CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  logic                               i_clk,
    input  pidl_pkg::t_cell_cmd                i_cmd,
    input  logic signed [pidl_pkg::DATA_W-1:0] i_left,
    input  logic signed [pidl_pkg::DATA_W-1:0] i_right,
    output logic signed [pidl_pkg::DATA_W-1:0] o_data,
    output logic signed [pidl_pkg::DATA_W-1:0] o_rd
);
    import pidl_pkg::*;

    localparam int IW = ($clog2(CAPACITY) > POS_W) ? $clog2(CAPACITY) : POS_W;
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [IW-1:0]            w_pos;
    logic                     w_eq;
    logic                     w_gt;

    assign w_pos = IW'(i_cmd.pos);
    assign w_eq  = (MY_IDX == w_pos);
    assign w_gt  = (MY_IDX > w_pos);

    // Insert takes the lower neighbor above the slot, delete takes the upper
    // neighbor from the slot on, and the slot itself takes the new value.
    always_comb begin
        n_data = r_data;
        if (i_cmd.shift_up && w_gt) begin
            n_data = i_left;
        end else if (i_cmd.shift_down && (w_gt || w_eq)) begin
            n_data = i_right;
        end else if (i_cmd.write && w_eq) begin
            n_data = i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (i_cmd.read && w_eq) ? r_data : '0;

endmodule

// ----- design/pidl_ctrl.sv -----
module pidl_ctrl #(
    parameter int CAPACITY = pidl_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [pidl_pkg::OP_W-1:0]          i_operation,
    input  logic [pidl_pkg::POS_W-1:0]         i_position,
    input  logic signed [pidl_pkg::DATA_W-1:0] i_value,
    output pidl_pkg::t_cell_cmd                o_cmd,
    output pidl_pkg::t_status                  o_status,
    output logic [pidl_pkg::CNT_OUT_W-1:0]     o_count
);
    import pidl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;
    t_cell_cmd        w_cmd;

    assign w_pos = CMP_W'(i_position);
    assign w_cnt = CMP_W'(r_count);

    always_comb begin
        n_count          = r_count;
        o_status         = ST_OK;
        w_cmd.shift_up   = 1'b0;
        w_cmd.shift_down = 1'b0;
        w_cmd.write      = 1'b0;
        w_cmd.read       = 1'b0;
        w_cmd.pos        = i_position;
        w_cmd.value      = i_value;
        case (t_op'(i_operation))
            OP_INSERT: begin
                if (r_count == CNT_FULL) begin
                    o_status = ST_FULL;
                end else if (w_pos > w_cnt) begin
                    o_status = ST_RANGE;
                end else begin
                    w_cmd.shift_up = 1'b1;
                    w_cmd.write    = 1'b1;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            OP_READ, OP_REPLACE, OP_DELETE: begin
                if (r_count == '0) begin
                    o_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    o_status = ST_RANGE;
                end else if (t_op'(i_operation) == OP_READ) begin
                    w_cmd.read = 1'b1;
                end else if (t_op'(i_operation) == OP_REPLACE) begin
                    w_cmd.write = 1'b1;
                end else begin
                    w_cmd.shift_down = 1'b1;
                    n_count          = r_count - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_cmd            = w_cmd;
        o_cmd.shift_up   = w_cmd.shift_up & i_accept;
        o_cmd.shift_down = w_cmd.shift_down & i_accept;
        o_cmd.write      = w_cmd.write & i_accept;
        o_cmd.read       = w_cmd.read & i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    assign o_count = CNT_OUT_W'(n_count);

endmodule

// ----- design/positional_insert_delete_list.sv -----
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_ready   i_operation, i_position, i_value
// result    out        o_valid / i_ready   o_status, o_read_data, o_entry_count
//
// The list is a row of cells that all shift toward their neighbors in the same
// cycle, and the result is written into a single output register. A new request
// is taken while the held result is being transferred, so back-to-back requests
// run at one per cycle as long as the result side keeps taking results.
// Reset clears the entry count and the output valid; cell contents are
// undefined until written. A stalled result blocks further requests.
module positional_insert_delete_list #(
    parameter int CAPACITY = pidl_pkg::CAPACITY_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [pidl_pkg::OP_W-1:0]             i_operation,
    input  logic [pidl_pkg::POS_W-1:0]            i_position,
    input  logic signed [pidl_pkg::DATA_W-1:0]    i_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [pidl_pkg::STATUS_W-1:0]         o_status,
    output logic signed [pidl_pkg::DATA_W-1:0]    o_read_data,
    output logic [pidl_pkg::CNT_OUT_W-1:0]        o_entry_count
);
    import pidl_pkg::*;

    logic                     w_accept;
    t_cell_cmd                w_cmd;
    t_status                  w_status;
    logic [CNT_OUT_W-1:0]     w_count;
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic [DATA_W-1:0][CAPACITY-1:0] w_rd_t;
    logic signed [DATA_W-1:0] w_read;

    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_status;
    logic signed [DATA_W-1:0] r_read_data;
    logic [CNT_OUT_W-1:0]     r_count;

    // The output register can take a new result whenever it is empty or its
    // current result is being transferred in this cycle.
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // The controller checks the request against the live count and turns it
    // into a command that every cell sees. The command is gated by the
    // transfer, so the cells only move on an accepted request.
    pidl_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_operation(i_operation),
        .i_position (i_position),
        .i_value    (i_value),
        .o_cmd      (w_cmd),
        .o_status   (w_status),
        .o_count    (w_count)
    );

    // The row of cells. Cell 0 has no lower neighbor; the top cell keeps its
    // own data on a delete, since that slot falls outside the list anyway.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        logic signed [DATA_W-1:0] w_rd;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        pidl_cell #(
            .CAPACITY(CAPACITY),
            .IDX     (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd),
            .i_left (w_left),
            .i_right(w_right),
            .o_data (w_data[g]),
            .o_rd   (w_rd)
        );

        for (genvar b = 0; b < DATA_W; b++) begin : g_bit
            assign w_rd_t[b][g] = w_rd[b];
        end
    end

    // Only the addressed cell drives its data on a successful read, every
    // other cell gives zero, so the read port is an OR across the row.
    always_comb begin
        for (int b = 0; b < DATA_W; b++) begin
            w_read[b] = |w_rd_t[b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_read_data <= w_read;
            r_count     <= w_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_read_data   = r_read_data;
    assign o_entry_count = r_count;

endmodule
